// ===== rtl/cpt_pkg.sv =====
// Shared widths and word types of the circumcircle point test pipeline.
`default_nettype none
package cpt_pkg;
	localparam int CW      = 32;
	localparam int FIELD_W = 32;
	localparam int NPTS    = 8;
	localparam int NRW     = 2 * CW;
	localparam int DPW     = 2 * CW + 1;
	localparam int DXW     = 2 * CW + 3;
	localparam int DMW     = 2 * CW + 2;
	localparam int NPW     = 2 * CW + 2;
	localparam int NXW     = 3 * CW + 4;
	localparam int QW      = 3 * CW + 3;
	localparam int UMW     = 3 * CW + 2;
	localparam int NCH     = (UMW + CW - 1) / CW;
	localparam int PW      = UMW + CW + 2;
	localparam int NDW     = 2 * CW + 2;
	localparam int SW      = PW + 3;

	typedef logic signed [CW-1:0] cpt_coord_t;
	typedef logic signed [CW:0]   cpt_diff_t;

	typedef struct packed {
		cpt_coord_t ax;
		cpt_coord_t ay;
		cpt_coord_t bx;
		cpt_coord_t by;
		cpt_coord_t cx;
		cpt_coord_t cy;
		cpt_coord_t qx;
		cpt_coord_t qy;
	} cpt_in_t;

	typedef struct packed {
		logic                   degen;
		logic                   sx;
		logic                   sy;
		cpt_diff_t              ex;
		cpt_diff_t              ey;
		logic signed [NDW-1:0]  nd;
	} cpt_side_t;

	typedef struct packed {
		logic [QW-1:0]  nx_mag;
		logic [QW-1:0]  ny_mag;
		logic [DMW-1:0] d_mag;
		cpt_side_t      side;
	} cpt_quo_in_t;
endpackage
`default_nettype wire

// ===== rtl/cpt_prep.sv =====
// Front pipeline: norms, cross-difference sums, magnitudes and signs.
`default_nettype none
module cpt_prep (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  cpt_pkg::cpt_in_t     in_pts,
	output logic                 out_valid,
	output cpt_pkg::cpt_quo_in_t out_word
);
	localparam int CW  = cpt_pkg::CW;
	localparam int NRW = cpt_pkg::NRW;
	localparam int DPW = cpt_pkg::DPW;
	localparam int DXW = cpt_pkg::DXW;
	localparam int NPW = cpt_pkg::NPW;
	localparam int NXW = cpt_pkg::NXW;
	localparam int NDW = cpt_pkg::NDW;
	localparam int QW  = cpt_pkg::QW;
	localparam int DMW = cpt_pkg::DMW;

	logic v_s1, v_s2, v_s3, v_s4;

	cpt_pkg::cpt_coord_t    cxs_s1 [3];
	logic signed [2*CW-1:0] sqx_s1 [4];
	logic signed [2*CW-1:0] sqy_s1 [4];
	cpt_pkg::cpt_diff_t     yd_s1 [3];
	cpt_pkg::cpt_diff_t     xd_s1 [3];
	cpt_pkg::cpt_diff_t     ex_s1, ey_s1;

	logic [NRW-1:0]         n_s2 [4];
	logic signed [DPW-1:0]  dp_s2 [3];
	cpt_pkg::cpt_diff_t     yd_s2 [3];
	cpt_pkg::cpt_diff_t     xd_s2 [3];
	cpt_pkg::cpt_diff_t     ex_s2, ey_s2;

	logic signed [NPW-1:0]  pxl_s3 [3];
	logic signed [NPW-1:0]  pxh_s3 [3];
	logic signed [NPW-1:0]  pyl_s3 [3];
	logic signed [NPW-1:0]  pyh_s3 [3];
	logic signed [DXW-1:0]  dx_s3;
	logic signed [NDW-1:0]  nd_s3;
	cpt_pkg::cpt_diff_t     ex_s3, ey_s3;

	logic signed [NXW-1:0]  nx_s4, ny_s4;
	logic signed [DXW-1:0]  dx_s4;
	logic signed [NDW-1:0]  nd_s4;
	cpt_pkg::cpt_diff_t     ex_s4, ey_s4;

	logic signed [NXW-1:0]  nx_sum, ny_sum, nx_abs, ny_abs;
	logic signed [DXW-1:0]  dx_abs;
	cpt_pkg::cpt_coord_t    ptx [4];
	cpt_pkg::cpt_coord_t    pty [4];

	always_comb begin
		ptx[0] = in_pts.ax; pty[0] = in_pts.ay;
		ptx[1] = in_pts.bx; pty[1] = in_pts.by;
		ptx[2] = in_pts.cx; pty[2] = in_pts.cy;
		ptx[3] = in_pts.qx; pty[3] = in_pts.qy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2; v_s4 <= v_s3; out_valid <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sqx_s1[i] <= ptx[i] * ptx[i];
				sqy_s1[i] <= pty[i] * pty[i];
			end
			for (int i = 0; i < 3; i++) cxs_s1[i] <= ptx[i];
			yd_s1[0] <= $signed({pty[2][CW-1], pty[2]}) - $signed({pty[1][CW-1], pty[1]});
			yd_s1[1] <= $signed({pty[0][CW-1], pty[0]}) - $signed({pty[2][CW-1], pty[2]});
			yd_s1[2] <= $signed({pty[1][CW-1], pty[1]}) - $signed({pty[0][CW-1], pty[0]});
			xd_s1[0] <= $signed({ptx[2][CW-1], ptx[2]}) - $signed({ptx[1][CW-1], ptx[1]});
			xd_s1[1] <= $signed({ptx[0][CW-1], ptx[0]}) - $signed({ptx[2][CW-1], ptx[2]});
			xd_s1[2] <= $signed({ptx[1][CW-1], ptx[1]}) - $signed({ptx[0][CW-1], ptx[0]});
			ex_s1 <= $signed({ptx[0][CW-1], ptx[0]}) - $signed({ptx[3][CW-1], ptx[3]});
			ey_s1 <= $signed({pty[0][CW-1], pty[0]}) - $signed({pty[3][CW-1], pty[3]});

			for (int i = 0; i < 4; i++) n_s2[i] <= $unsigned(sqx_s1[i]) + $unsigned(sqy_s1[i]);
			for (int i = 0; i < 3; i++) begin
				dp_s2[i] <= cxs_s1[i] * yd_s1[i];
				yd_s2[i] <= yd_s1[i];
				xd_s2[i] <= xd_s1[i];
			end
			ex_s2 <= ex_s1;
			ey_s2 <= ey_s1;

			for (int i = 0; i < 3; i++) begin
				pxl_s3[i] <= $signed({1'b0, n_s2[i][CW-1:0]}) * yd_s2[i];
				pxh_s3[i] <= $signed({1'b0, n_s2[i][NRW-1:CW]}) * yd_s2[i];
				pyl_s3[i] <= $signed({1'b0, n_s2[i][CW-1:0]}) * xd_s2[i];
				pyh_s3[i] <= $signed({1'b0, n_s2[i][NRW-1:CW]}) * xd_s2[i];
			end
			dx_s3 <= DXW'(dp_s2[0]) + DXW'(dp_s2[1]) + DXW'(dp_s2[2]);
			nd_s3 <= $signed({2'b00, n_s2[0]}) - $signed({2'b00, n_s2[3]});
			ex_s3 <= ex_s2;
			ey_s3 <= ey_s2;

			nx_s4 <= nx_sum;
			ny_s4 <= ny_sum;
			dx_s4 <= dx_s3;
			nd_s4 <= nd_s3;
			ex_s4 <= ex_s3;
			ey_s4 <= ey_s3;

			out_word.nx_mag     <= nx_abs[QW-1:0];
			out_word.ny_mag     <= ny_abs[QW-1:0];
			out_word.d_mag      <= dx_abs[DMW-1:0];
			out_word.side.degen <= (dx_s4 == '0);
			out_word.side.sx    <= nx_s4[NXW-1] ^ dx_s4[DXW-1];
			out_word.side.sy    <= ny_s4[NXW-1] ^ ~dx_s4[DXW-1];
			out_word.side.ex    <= ex_s4;
			out_word.side.ey    <= ey_s4;
			out_word.side.nd    <= nd_s4;
		end
	end

	always_comb begin
		nx_sum = '0;
		ny_sum = '0;
		for (int i = 0; i < 3; i++) begin
			nx_sum = nx_sum + (NXW'(pxh_s3[i]) <<< CW) + NXW'(pxl_s3[i]);
			ny_sum = ny_sum + (NXW'(pyh_s3[i]) <<< CW) + NXW'(pyl_s3[i]);
		end
		nx_abs = nx_s4[NXW-1] ? -nx_s4 : nx_s4;
		ny_abs = ny_s4[NXW-1] ? -ny_s4 : ny_s4;
		dx_abs = dx_s4[DXW-1] ? -dx_s4 : dx_s4;
	end
endmodule
`default_nettype wire

// ===== rtl/cpt_div.sv =====
// Dual-lane restoring divider, one quotient bit per pipeline stage.
`default_nettype none
module cpt_div (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  en,
	input  wire                  in_valid,
	input  cpt_pkg::cpt_quo_in_t in_word,
	output logic                 out_valid,
	output logic [cpt_pkg::QW-1:0] quo_x,
	output logic [cpt_pkg::QW-1:0] quo_y,
	output cpt_pkg::cpt_side_t   out_side
);
	localparam int QW  = cpt_pkg::QW;
	localparam int DMW = cpt_pkg::DMW;

	logic                v_s    [QW+1];
	logic [DMW-1:0]      rx_s   [QW+1];
	logic [DMW-1:0]      ry_s   [QW+1];
	logic [QW-1:0]       nqx_s  [QW+1];
	logic [QW-1:0]       nqy_s  [QW+1];
	logic [DMW-1:0]      d_s    [QW+1];
	cpt_pkg::cpt_side_t  side_s [QW+1];

	assign v_s[0]    = in_valid;
	assign rx_s[0]   = '0;
	assign ry_s[0]   = '0;
	assign nqx_s[0]  = in_word.nx_mag;
	assign nqy_s[0]  = in_word.ny_mag;
	assign d_s[0]    = in_word.d_mag;
	assign side_s[0] = in_word.side;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DMW:0] tx, ty, dd;
		logic         gx, gy;

		always_comb begin
			dd = {1'b0, d_s[k]};
			tx = {rx_s[k], nqx_s[k][QW-1]};
			ty = {ry_s[k], nqy_s[k][QW-1]};
			gx = (tx >= dd);
			gy = (ty >= dd);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rx_s[k+1]   <= gx ? DMW'(tx - dd) : tx[DMW-1:0];
				ry_s[k+1]   <= gy ? DMW'(ty - dd) : ty[DMW-1:0];
				nqx_s[k+1]  <= {nqx_s[k][QW-2:0], gx};
				nqy_s[k+1]  <= {nqy_s[k][QW-2:0], gy};
				d_s[k+1]    <= d_s[k];
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_valid = v_s[QW];
	assign quo_x     = nqx_s[QW];
	assign quo_y     = nqy_s[QW];
	assign out_side  = side_s[QW];
endmodule
`default_nettype wire

// ===== rtl/cpt_cmp.sv =====
// Back pipeline: halve the quotients, form the distance difference, decide.
`default_nettype none
module cpt_cmp (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    en,
	input  wire                    in_valid,
	input  logic [cpt_pkg::QW-1:0] quo_x,
	input  logic [cpt_pkg::QW-1:0] quo_y,
	input  cpt_pkg::cpt_side_t     in_side,
	output logic                   out_valid,
	output logic                   inside_res,
	output logic                   degenerate
);
	localparam int CW  = cpt_pkg::CW;
	localparam int QW  = cpt_pkg::QW;
	localparam int NCH = cpt_pkg::NCH;
	localparam int PW  = cpt_pkg::PW;
	localparam int SW  = cpt_pkg::SW;
	localparam int NDW = cpt_pkg::NDW;

	logic [NCH*CW-1:0]       ux_pad, uy_pad;
	logic signed [2*CW+1:0]  ppx_s1 [NCH];
	logic signed [2*CW+1:0]  ppy_s1 [NCH];
	cpt_pkg::cpt_side_t      side_s1;
	logic signed [PW-1:0]    px_sum, py_sum;
	logic signed [PW-1:0]    px_s2, py_s2;
	logic signed [NDW-1:0]   nd_s2;
	logic                    degen_s2;
	logic signed [SW-1:0]    diff;
	logic                    v_s1, v_s2;

	assign ux_pad = (NCH*CW)'(quo_x[QW-1:1]);
	assign uy_pad = (NCH*CW)'(quo_y[QW-1:1]);

	always_comb begin
		px_sum = '0;
		py_sum = '0;
		for (int k = 0; k < NCH; k++) begin
			px_sum = px_sum + (PW'(ppx_s1[k]) <<< (k * CW));
			py_sum = py_sum + (PW'(ppy_s1[k]) <<< (k * CW));
		end
		diff = SW'(nd_s2) - ((SW'(px_s2) + SW'(py_s2)) <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid; v_s2 <= v_s1; out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NCH; k++) begin
				ppx_s1[k] <= $signed({1'b0, ux_pad[k*CW +: CW]}) * in_side.ex;
				ppy_s1[k] <= $signed({1'b0, uy_pad[k*CW +: CW]}) * in_side.ey;
			end
			side_s1 <= in_side;

			px_s2    <= side_s1.sx ? -px_sum : px_sum;
			py_s2    <= side_s1.sy ? -py_sum : py_sum;
			nd_s2    <= side_s1.nd;
			degen_s2 <= side_s1.degen;

			inside_res <= ~diff[SW-1] & ~degen_s2;
			degenerate <= degen_s2;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/circumcircle_point_test.sv =====
// Top level of the circumcircle point test: stream ports and pipeline glue.
// Takes one word per cycle while s_tready is high: three triangle corners and a
// query point, signed fixed point, and returns inside_res (query on or within
// the circumcircle) and degenerate (collinear corners, inside_res then 0). The
// depth is dominated by the two bit-per-stage quotient pipelines; throughput is
// one word per cycle. Ready drops only while the output word is held back.
`default_nettype none
module circumcircle_point_test (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	// corner_a_x, corner_a_y, corner_b_x, corner_b_y,
	// corner_c_x, corner_c_y, query_x, query_y (32 bits each)
	input  wire [255:0] s_tdata,
	output logic        m_tvalid,
	input  wire         m_tready,
	// inside_res, degenerate, zero fill
	output logic [7:0]  m_tdata
);
	localparam int CW = cpt_pkg::CW;
	localparam int FW = cpt_pkg::FIELD_W;

	logic                  en;
	cpt_pkg::cpt_in_t      pts;
	logic                  prep_v, div_v;
	cpt_pkg::cpt_quo_in_t  prep_w;
	logic [cpt_pkg::QW-1:0] qx, qy;
	cpt_pkg::cpt_side_t    div_side;
	logic                  inside_res, degenerate;

	assign en       = ~m_tvalid | m_tready;
	assign s_tready = en;

	assign pts.ax = s_tdata[0*FW +: CW];
	assign pts.ay = s_tdata[1*FW +: CW];
	assign pts.bx = s_tdata[2*FW +: CW];
	assign pts.by = s_tdata[3*FW +: CW];
	assign pts.cx = s_tdata[4*FW +: CW];
	assign pts.cy = s_tdata[5*FW +: CW];
	assign pts.qx = s_tdata[6*FW +: CW];
	assign pts.qy = s_tdata[7*FW +: CW];

	cpt_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_pts    (pts),
		.out_valid (prep_v),
		.out_word  (prep_w)
	);

	cpt_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (prep_v),
		.in_word   (prep_w),
		.out_valid (div_v),
		.quo_x     (qx),
		.quo_y     (qy),
		.out_side  (div_side)
	);

	cpt_cmp u_cmp (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (div_v),
		.quo_x      (qx),
		.quo_y      (qy),
		.in_side    (div_side),
		.out_valid  (m_tvalid),
		.inside_res (inside_res),
		.degenerate (degenerate)
	);

	assign m_tdata = {6'b000000, degenerate, inside_res};

	a_degen_not_inside: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> !m_tdata[0])
		else $error("degenerate word reports inside");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7:2] == 6'b000000)
		else $error("output fill bits set");
endmodule
`default_nettype wire
